// ----- rtl/core/fmop_pkg.sv -----
// shared types, constants and table math for the fm operator
`timescale 1ns / 1ps

package fmop_pkg;

    // parameter defaults
    localparam int TABLE_BITS_DEF  = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    // field and register widths
    localparam int PHASE_W    = 32;
    localparam int FIELD_W    = 24;
    localparam int AMP_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int SCALE_W    = 20;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int TDATA_S_W  = 24;
    localparam int TDATA_M_W  = 48;

    // fixed point shifts
    localparam int GAIN_FRAC = 12;
    localparam int AMP_FRAC  = 8;
    localparam int INC_FRAC  = 6;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_AMPLITUDE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_FREQ   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FB_GAIN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_SCALE = 2'd3;

    // register reset values
    localparam logic signed [AMP_W-1:0]   AMP_RESET   = 16'sd256;
    localparam logic signed [FIELD_W-1:0] BASE_RESET  = 24'sd28160;
    localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 16'sd0;
    localparam logic [SCALE_W-1:0]        SCALE_RESET = 20'd12173;

    typedef logic signed [FIELD_W-1:0] field_t;
    typedef logic signed [39:0]        sat_in_t;
    typedef logic signed [39:0]        fb_prod_t;
    typedef logic signed [44:0]        inc_prod_t;

    localparam field_t  FIELD_MAX = 24'sh7FFFFF;
    localparam field_t  FIELD_MIN = -24'sh800000;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // clamp to the signed 24 bit range
    function automatic field_t sat24(input sat_in_t v);
        if (v > sat_in_t'(FIELD_MAX)) begin
            return FIELD_MAX;
        end else if (v < sat_in_t'(FIELD_MIN)) begin
            return FIELD_MIN;
        end
        return field_t'(v);
    endfunction

    // first quadrant cosine magnitude, taylor series in q30, elaboration only
    function automatic longint quarter_cos(input int unsigned k,
                                           input int unsigned table_bits,
                                           input int unsigned sample_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned mag;
        longint unsigned cap;
        longint          c;
        int unsigned     sh;
        x    = (HALF_PI_Q30 * 64'(k) + (64'd1 << (table_bits - 3))) >> (table_bits - 2);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        c    = $signed(term);
        term = ((term * x2) >> 30) / 2;   c = c - $signed(term);
        term = ((term * x2) >> 30) / 12;  c = c + $signed(term);
        term = ((term * x2) >> 30) / 30;  c = c - $signed(term);
        term = ((term * x2) >> 30) / 56;  c = c + $signed(term);
        term = ((term * x2) >> 30) / 90;  c = c - $signed(term);
        term = ((term * x2) >> 30) / 132; c = c + $signed(term);
        term = ((term * x2) >> 30) / 182; c = c - $signed(term);
        term = ((term * x2) >> 30) / 240; c = c + $signed(term);
        term = ((term * x2) >> 30) / 306; c = c - $signed(term);
        term = ((term * x2) >> 30) / 380; c = c + $signed(term);
        term = ((term * x2) >> 30) / 462; c = c - $signed(term);
        if (c < 0) begin
            c = 0;
        end
        sh  = 31 - sample_bits;
        mag = ($unsigned(c) + (64'd1 << (sh - 1))) >> sh;
        cap = (64'd1 << (sample_bits - 1)) - 64'd1;
        if (mag > cap) begin
            mag = cap;
        end
        return $signed(mag);
    endfunction

endpackage

// ----- rtl/core/fmop_cos_rom.sv -----
// cosine table rom, two read ports, registered read data
`timescale 1ns / 1ps

module fmop_cos_rom #(
    parameter int TABLE_BITS  = fmop_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = fmop_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [TABLE_BITS:0]           addr_a,
    input  logic [TABLE_BITS:0]           addr_b,
    output logic signed [SAMPLE_BITS-1:0] data_a,
    output logic signed [SAMPLE_BITS-1:0] data_b
);

    localparam int DEPTH   = (1 << TABLE_BITS) + 1;
    localparam int QUARTER = 1 << (TABLE_BITS - 2);

    localparam int unsigned QUAD_FIRST  = 0;
    localparam int unsigned QUAD_SECOND = 1;
    localparam int unsigned QUAD_THIRD  = 2;

    typedef logic signed [SAMPLE_BITS-1:0] rom_t [0:DEPTH-1];

    // one full period plus the wrap entry
    function automatic rom_t build_rom();
        rom_t        r;
        int unsigned m;
        int unsigned quad;
        int unsigned rem;
        longint      v;
        for (int unsigned n = 0; n < DEPTH; n++) begin
            m    = n & ((1 << TABLE_BITS) - 1);
            quad = m >> (TABLE_BITS - 2);
            rem  = m & (QUARTER - 1);
            case (quad)
                QUAD_FIRST: begin
                    v = fmop_pkg::quarter_cos(rem, TABLE_BITS, SAMPLE_BITS);
                end
                QUAD_SECOND: begin
                    v = -fmop_pkg::quarter_cos(QUARTER - rem, TABLE_BITS, SAMPLE_BITS);
                end
                QUAD_THIRD: begin
                    v = -fmop_pkg::quarter_cos(rem, TABLE_BITS, SAMPLE_BITS);
                end
                default: begin
                    v = fmop_pkg::quarter_cos(QUARTER - rem, TABLE_BITS, SAMPLE_BITS);
                end
            endcase
            r[n] = SAMPLE_BITS'(v);
        end
        return r;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic signed [SAMPLE_BITS-1:0] data_a_reg;
    logic signed [SAMPLE_BITS-1:0] data_b_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            data_a_reg <= COS_ROM[addr_a];
            data_b_reg <= COS_ROM[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

// ----- rtl/core/fm_operator_with_feedback.sv -----
// fm operator with self feedback: top level
// an item passes the core states INTERP, STEP, MULT and SAT, then the three tail stages
// a new item is taken only once the core is back in ST_IDLE, set by the feedback loop through the multipliers
// s_tready is high only while the operator core is empty; three tail stages drain on their own
// reset (aresetn low, synchronous): phase and feedback zero, registers to defaults, no item held
`timescale 1ns / 1ps

module fm_operator_with_feedback #(
    parameter int TABLE_BITS  = fmop_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_BITS = fmop_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [fmop_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [fmop_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fmop_pkg::TDATA_S_W-1:0]      s_tdata,   // [23:0] mod_in
    // result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [fmop_pkg::TDATA_M_W-1:0]      m_tdata    // [23:0] audio_out, [47:24] mod_out
);

    localparam int FRAC_BITS = fmop_pkg::PHASE_W - TABLE_BITS;
    localparam int IP_W      = FRAC_BITS + SAMPLE_BITS + 2;
    localparam int SF_W      = SAMPLE_BITS + fmop_pkg::FIELD_W;
    localparam int AP_W      = SAMPLE_BITS + fmop_pkg::AMP_W;

    typedef logic signed [IP_W-1:0]      ip_t;
    typedef logic signed [SF_W-1:0]      sf_t;
    typedef logic signed [AP_W-1:0]      ap_t;
    typedef logic signed [SAMPLE_BITS:0] diff_t;

    localparam ip_t                 IP_HALF  = ip_t'(1) <<< (FRAC_BITS - 1);
    localparam sf_t                 SF_HALF  = sf_t'(1) <<< (SAMPLE_BITS - 2);
    localparam ap_t                 AP_HALF  = ap_t'(1) <<< (fmop_pkg::AMP_FRAC - 1);
    localparam fmop_pkg::fb_prod_t  FB_HALF  =
        fmop_pkg::fb_prod_t'(1) <<< (fmop_pkg::GAIN_FRAC - 1);
    localparam fmop_pkg::fb_prod_t  MOD_HALF =
        fmop_pkg::fb_prod_t'(1) <<< (fmop_pkg::AMP_FRAC - 1);
    localparam fmop_pkg::inc_prod_t INC_BIAS =
        (fmop_pkg::inc_prod_t'(1) <<< fmop_pkg::INC_FRAC) - fmop_pkg::inc_prod_t'(1);

    // core sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;   // waiting for an item, rom read issued on accept
    localparam logic [2:0] ST_INTERP = 3'd1;   // rom data back, interpolation product, frequency
    localparam logic [2:0] ST_STEP   = 3'd2;   // cosine sample, phase increment product
    localparam logic [2:0] ST_MULT   = 3'd3;   // feedback and audio products, phase advance
    localparam logic [2:0] ST_SAT    = 3'd4;   // feedback written back, hand off to tail

    // configuration registers
    logic signed [fmop_pkg::AMP_W-1:0]   amp_reg;
    logic signed [fmop_pkg::FIELD_W-1:0] base_reg;
    logic signed [fmop_pkg::GAIN_W-1:0]  gain_reg;
    logic [fmop_pkg::SCALE_W-1:0]        scale_reg;

    // operator state
    logic [fmop_pkg::PHASE_W-1:0]        phase_reg;
    logic [fmop_pkg::PHASE_W-1:0]        phase_next;
    fmop_pkg::field_t                    fb_reg;
    fmop_pkg::field_t                    fb_next;

    // control
    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;
    logic       sat_fire;
    logic       pend_valid_reg;
    logic       pend_take;
    logic       mv_valid_reg;
    logic       mv_take;
    logic       m_tvalid_reg;

    // core datapath
    fmop_pkg::field_t              mod_reg;
    fmop_pkg::fb_prod_t            fb_prod_reg;
    fmop_pkg::sat_in_t             fbt;
    fmop_pkg::sat_in_t             f_sum;
    fmop_pkg::field_t              f_reg;
    logic signed [SAMPLE_BITS-1:0] t0_reg;
    diff_t                         diff;
    logic signed [FRAC_BITS:0]     fr_s;
    ip_t                           interp_prod_reg;
    ip_t                           interp_rnd;
    diff_t                         interp_term;
    diff_t                         s_wide;
    logic signed [SAMPLE_BITS-1:0] s_reg;
    fmop_pkg::inc_prod_t           inc_prod_reg;
    fmop_pkg::inc_prod_t           inc_adj;
    fmop_pkg::inc_prod_t           inc_q;
    sf_t                           sf_prod_reg;
    sf_t                           sf_rnd;
    ap_t                           audio_prod_reg;
    ap_t                           ap_rnd;
    fmop_pkg::field_t              audio_next;

    // tail
    fmop_pkg::field_t              audio_pend_reg;
    fmop_pkg::fb_prod_t            mprod_reg;
    fmop_pkg::fb_prod_t            mod_rnd;
    fmop_pkg::field_t              maudio_reg;
    fmop_pkg::field_t              mod_sat;
    logic [fmop_pkg::TDATA_M_W-1:0] m_tdata_reg;

    // rom
    logic [TABLE_BITS-1:0]         idx;
    logic [TABLE_BITS:0]           rom_addr_a;
    logic [TABLE_BITS:0]           rom_addr_b;
    logic signed [SAMPLE_BITS-1:0] rom_a;
    logic signed [SAMPLE_BITS-1:0] rom_b;

    // handshakes
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign mv_take   = mv_valid_reg && (!m_tvalid_reg || m_tready);
    assign pend_take = pend_valid_reg && (!mv_valid_reg || mv_take);
    // feedback write-back waits while the tail is full
    assign sat_fire  = (state_reg == ST_SAT) && (!pend_valid_reg || pend_take);

    // both neighbors of the interpolation are read in the same cycle
    assign idx        = phase_reg[fmop_pkg::PHASE_W-1 -: TABLE_BITS];
    assign rom_addr_a = {1'b0, idx};
    assign rom_addr_b = {1'b0, idx} + (TABLE_BITS+1)'(1);

    fmop_cos_rom #(
        .TABLE_BITS  (TABLE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cos_rom (
        .aclk   (aclk),
        .rd_en  (accept),
        .addr_a (rom_addr_a),
        .addr_b (rom_addr_b),
        .data_a (rom_a),
        .data_b (rom_b)
    );

    // instantaneous frequency: base + rounded feedback term + modulation, saturated
    assign fbt   = (fb_prod_reg + FB_HALF) >>> fmop_pkg::GAIN_FRAC;
    assign f_sum = fbt + fmop_pkg::sat_in_t'(base_reg) + fmop_pkg::sat_in_t'(mod_reg);

    // linear interpolation between neighbors
    assign diff        = diff_t'(rom_b) - diff_t'(rom_a);
    assign fr_s        = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign interp_rnd  = (interp_prod_reg + IP_HALF) >>> FRAC_BITS;
    assign interp_term = interp_rnd[SAMPLE_BITS:0];
    assign s_wide      = diff_t'(t0_reg) + interp_term;

    // phase increment, truncated toward zero
    assign inc_adj    = inc_prod_reg + (inc_prod_reg[$bits(inc_prod_reg)-1] ?
                                        INC_BIAS : fmop_pkg::inc_prod_t'(0));
    assign inc_q      = inc_adj >>> fmop_pkg::INC_FRAC;
    assign phase_next = phase_reg + inc_q[fmop_pkg::PHASE_W-1:0];

    // new feedback frequency and audio sample
    assign sf_rnd     = (sf_prod_reg + SF_HALF) >>> (SAMPLE_BITS - 1);
    assign fb_next    = fmop_pkg::sat24(fmop_pkg::sat_in_t'($signed(sf_rnd[fmop_pkg::FIELD_W:0])));
    assign ap_rnd     = (audio_prod_reg + AP_HALF) >>> fmop_pkg::AMP_FRAC;
    assign audio_next = fmop_pkg::sat24(fmop_pkg::sat_in_t'($signed(ap_rnd[SAMPLE_BITS+7:0])));

    // modulator output from the tail product
    assign mod_rnd = (mprod_reg + MOD_HALF) >>> fmop_pkg::AMP_FRAC;
    assign mod_sat = fmop_pkg::sat24(fmop_pkg::sat_in_t'($signed(mod_rnd[31:0])));

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_INTERP;
                end
            end
            ST_INTERP: begin
                state_next = ST_STEP;
            end
            ST_STEP: begin
                state_next = ST_MULT;
            end
            ST_MULT: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                if (sat_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            mv_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            phase_reg      <= '0;
            fb_reg         <= '0;
            amp_reg        <= fmop_pkg::AMP_RESET;
            base_reg       <= fmop_pkg::BASE_RESET;
            gain_reg       <= fmop_pkg::GAIN_RESET;
            scale_reg      <= fmop_pkg::SCALE_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_MULT) begin
                phase_reg <= phase_next;
            end
            if (sat_fire) begin
                fb_reg         <= fb_next;
                pend_valid_reg <= 1'b1;
            end else if (pend_take) begin
                pend_valid_reg <= 1'b0;
            end
            if (pend_take) begin
                mv_valid_reg <= 1'b1;
            end else if (mv_take) begin
                mv_valid_reg <= 1'b0;
            end
            if (mv_take) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    fmop_pkg::REG_AMPLITUDE: begin
                        amp_reg <= cfg_wr_data[fmop_pkg::AMP_W-1:0];
                    end
                    fmop_pkg::REG_BASE_FREQ: begin
                        base_reg <= cfg_wr_data[fmop_pkg::FIELD_W-1:0];
                    end
                    fmop_pkg::REG_FB_GAIN: begin
                        gain_reg <= cfg_wr_data[fmop_pkg::GAIN_W-1:0];
                    end
                    fmop_pkg::REG_PHASE_SCALE: begin
                        scale_reg <= cfg_wr_data[fmop_pkg::SCALE_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, one multiplier per stage but two in ST_MULT
    always_ff @(posedge aclk) begin
        if (accept) begin
            mod_reg     <= s_tdata[fmop_pkg::FIELD_W-1:0];
            fb_prod_reg <= fmop_pkg::fb_prod_t'(fb_reg) * fmop_pkg::fb_prod_t'(gain_reg);
        end
        if (state_reg == ST_INTERP) begin
            t0_reg          <= rom_a;
            interp_prod_reg <= ip_t'(fr_s) * ip_t'(diff);
            f_reg           <= fmop_pkg::sat24(f_sum);
        end
        if (state_reg == ST_STEP) begin
            s_reg        <= s_wide[SAMPLE_BITS-1:0];
            inc_prod_reg <= fmop_pkg::inc_prod_t'(f_reg) *
                            fmop_pkg::inc_prod_t'($signed({1'b0, scale_reg}));
        end
        if (state_reg == ST_MULT) begin
            sf_prod_reg    <= sf_t'(s_reg) * sf_t'(f_reg);
            audio_prod_reg <= ap_t'(amp_reg) * ap_t'(s_reg);
        end
        if (sat_fire) begin
            audio_pend_reg <= audio_next;
        end
        // fb_reg still holds the pending item's feedback here
        if (pend_take) begin
            mprod_reg  <= fmop_pkg::fb_prod_t'(fb_reg) * fmop_pkg::fb_prod_t'(amp_reg);
            maudio_reg <= audio_pend_reg;
        end
        if (mv_take) begin
            m_tdata_reg <= {mod_sat, maudio_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/core/fmop_checker.sv -----
// port level checks for the fm operator and the bind that attaches them
`timescale 1ns / 1ps

module fmop_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [fmop_pkg::TDATA_M_W-1:0]     m_tdata
);

    localparam logic [2:0] MAX_IN_FLIGHT = 3'd4;

    logic       in_acc;
    logic       out_acc;
    logic [2:0] outst_reg;

    assign in_acc  = s_tvalid && s_tready;
    assign out_acc = m_tvalid && m_tready;

    // items taken in and not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outst_reg <= '0;
        end else if (in_acc && !out_acc) begin
            outst_reg <= outst_reg + 3'd1;
        end else if (out_acc && !in_acc) begin
            outst_reg <= outst_reg - 3'd1;
        end
    end

    // the core drops s_tready after taking an item and keeps it low while busy
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input taken again within the core's busy window");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    // no result without an item behind it
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> outst_reg != 3'd0)
        else $error("result shown with no item outstanding");

    // core plus three tail stages bound the items in flight
    a_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        outst_reg <= MAX_IN_FLIGHT)
        else $error("more items in flight than stages");

endmodule

bind fm_operator_with_feedback fmop_checker u_fmop_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- verif/fm_operator_with_feedback_tb.sv -----
// self-checking testbench for the fm operator with feedback: directed table, then random items
`timescale 1ns / 1ps

module fm_operator_with_feedback_tb;

    // geometry of the cosine rom and fixed point shifts, kept at the block defaults
    localparam int TBL_BITS   = fmop_pkg::TABLE_BITS_DEF;
    localparam int SMP_BITS   = fmop_pkg::SAMPLE_BITS_DEF;
    localparam int FULL_WAVE  = 1 << TBL_BITS;
    localparam int QTR_WAVE   = FULL_WAVE >> 2;
    localparam int COS_LEN    = FULL_WAVE + 1;
    localparam int PH_FRAC    = fmop_pkg::PHASE_W - TBL_BITS;
    localparam int SMP_FRAC   = SMP_BITS - 1;
    localparam int MAG_SHIFT  = 31 - SMP_BITS;
    localparam longint unsigned MAG_CAP = (64'd1 << (SMP_BITS - 1)) - 64'd1;
    localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

    // run control
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 12;
    localparam int NUM_SEGMENTS   = 24;
    localparam int SEG_ITEMS      = 48;
    localparam int N_DIRECTED     = 19;

    // one result item: audio sample and deviation for the next operator
    typedef struct packed {
        fmop_pkg::field_t audio;
        fmop_pkg::field_t modv;
    } op_sample_t;

    // directed stimulus row: optional register write before the item, optional typed result
    typedef struct packed {
        logic                            wr;
        logic [fmop_pkg::CFG_ADDR_W-1:0] reg_idx;
        logic [fmop_pkg::CFG_DATA_W-1:0] reg_val;
        logic [fmop_pkg::FIELD_W-1:0]    mod_in;
        logic                            known;
        logic [fmop_pkg::FIELD_W-1:0]    aud_k;
        logic [fmop_pkg::FIELD_W-1:0]    mod_k;
    } dir_row_t;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [fmop_pkg::CFG_ADDR_W-1:0] cfg_addr    = '0;
    logic [fmop_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [fmop_pkg::TDATA_S_W-1:0]  s_tdata     = '0;   // [23:0] mod_in
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [fmop_pkg::TDATA_M_W-1:0]  m_tdata;   // [23:0] audio_out, [47:24] mod_out

    // typed expectation travelling alongside the item on the input side
    logic                            row_known   = 1'b0;
    logic [fmop_pkg::FIELD_W-1:0]    row_audio   = '0;
    logic [fmop_pkg::FIELD_W-1:0]    row_mod     = '0;

    // idling percentages for the current phase
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;

    int                      err_count    = 0;
    int                      stall_cycles = 0;

    // predictor state: its own copy of the registers, phase, feedback and rom
    logic signed [fmop_pkg::AMP_W-1:0]  amp_reg;
    fmop_pkg::field_t                   base_reg;
    logic signed [fmop_pkg::GAIN_W-1:0] gain_reg;
    logic [fmop_pkg::SCALE_W-1:0]       scale_reg;
    logic [fmop_pkg::PHASE_W-1:0]       osc_phase;
    fmop_pkg::field_t                   fb_freq;
    logic signed [SMP_BITS-1:0]         cos_rom [0:COS_LEN-1];

    // results still owed by the block, oldest first
    op_sample_t operator_outputs[$];

    // directed items: after reset, field extremes, register extremes and the special cases
    dir_row_t directed_rows [0:N_DIRECTED-1] = '{
        // first item after reset: phase zero, amplitude 1.0, 440 hz
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h000000, 1'b1, 24'h007FFF, 24'h006DFF},
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h800000, 1'b0, 24'h0, 24'h0},
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'hFFFFFF, 1'b0, 24'h0, 24'h0},
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h000001, 1'b0, 24'h0, 24'h0},
        // amplitude extremes, junk above the register width
        '{1'b1, fmop_pkg::REG_AMPLITUDE, 24'hA57FFF, 24'h555555, 1'b0, 24'h0, 24'h0},
        '{1'b1, fmop_pkg::REG_AMPLITUDE, 24'h5A8000, 24'hAAAAAA, 1'b0, 24'h0, 24'h0},
        // feedback gain extremes
        '{1'b1, fmop_pkg::REG_FB_GAIN, 24'hC37FFF, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{1'b1, fmop_pkg::REG_FB_GAIN, 24'h3C8000, 24'h123456, 1'b0, 24'h0, 24'h0},
        // frequency overflow both ways, negative frequency runs the phase backwards
        '{1'b1, fmop_pkg::REG_BASE_FREQ, 24'h7FFFFF, 24'h7FFFFF, 1'b0, 24'h0, 24'h0},
        '{1'b1, fmop_pkg::REG_BASE_FREQ, 24'h800000, 24'h800000, 1'b0, 24'h0, 24'h0},
        // zero phase scale freezes the phase
        '{1'b1, fmop_pkg::REG_PHASE_SCALE, 24'hF00000, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{1'b0, fmop_pkg::REG_PHASE_SCALE, 24'h000000, 24'h3FFFFF, 1'b0, 24'h0, 24'h0},
        // largest phase scale, then the smallest nonzero one
        '{1'b1, fmop_pkg::REG_PHASE_SCALE, 24'h0FFFFF, 24'h400000, 1'b0, 24'h0, 24'h0},
        '{1'b1, fmop_pkg::REG_PHASE_SCALE, 24'hF00001, 24'hC00000, 1'b0, 24'h0, 24'h0},
        '{1'b1, fmop_pkg::REG_FB_GAIN, 24'h001000, 24'h000000, 1'b0, 24'h0, 24'h0},
        // zero amplitude silences both outputs
        '{1'b1, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h7FFFFF, 1'b1, 24'h000000, 24'h000000},
        '{1'b1, fmop_pkg::REG_BASE_FREQ, 24'h006E00, 24'h000000, 1'b0, 24'h0, 24'h0},
        '{1'b0, fmop_pkg::REG_AMPLITUDE, 24'h000000, 24'h000000, 1'b0, 24'h0, 24'h0}
    };

    fm_operator_with_feedback dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // 100 mhz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // add half an lsb, then floor
    function automatic longint rnd_shr(input longint v, input int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic fmop_pkg::field_t clamp24(input longint v);
        if (v > fmop_pkg::FIELD_MAX) begin
            return fmop_pkg::FIELD_MAX;
        end else if (v < fmop_pkg::FIELD_MIN) begin
            return fmop_pkg::FIELD_MIN;
        end
        return v[fmop_pkg::FIELD_W-1:0];
    endfunction

    // first quadrant cosine magnitude from a 12 term series in q30
    function automatic int quarter_wave(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned mag;
        longint          acc;
        int              i;
        x    = (PI_HALF_Q30 * longint'(k) + QTR_WAVE / 2) / QTR_WAVE;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        acc  = longint'(term);
        for (i = 1; i <= 11; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        mag = (acc + (64'd1 << (MAG_SHIFT - 1))) >> MAG_SHIFT;
        // full scale 1.0 does not fit the sample width
        if (mag > MAG_CAP) begin
            mag = MAG_CAP;
        end
        return int'(mag);
    endfunction

    // full period from the first quadrant by symmetry, one guard entry at the end
    function automatic void fill_cos_rom();
        int n;
        int m;
        int r;
        int v;
        for (n = 0; n < COS_LEN; n++) begin
            m = n % FULL_WAVE;
            r = m % QTR_WAVE;
            case (m / QTR_WAVE)
                0: v = quarter_wave(r);
                1: v = -quarter_wave(QTR_WAVE - r);
                2: v = -quarter_wave(r);
                default: v = quarter_wave(QTR_WAVE - r);
            endcase
            cos_rom[n] = v[SMP_BITS-1:0];
        end
    endfunction

    function automatic void reset_operator();
        fill_cos_rom();
        osc_phase = '0;
        fb_freq   = '0;
        amp_reg   = fmop_pkg::AMP_RESET;
        base_reg  = fmop_pkg::BASE_RESET;
        gain_reg  = fmop_pkg::GAIN_RESET;
        scale_reg = fmop_pkg::SCALE_RESET;
    endfunction

    // one modulation sample in, one operator sample out; advances phase and feedback
    function automatic void advance_operator(input fmop_pkg::field_t mod_in,
                                             output op_sample_t res);
        longint fbt;
        longint freq;
        longint fr;
        longint t0;
        longint t1;
        longint smp;
        longint prod;
        longint step;
        int     idx;
        fbt  = rnd_shr(longint'(fb_freq) * longint'(gain_reg), fmop_pkg::GAIN_FRAC);
        freq = longint'(clamp24(longint'(base_reg) + fbt + longint'(mod_in)));
        // interpolate between neighboring rom entries on the phase fraction
        idx  = int'(osc_phase[fmop_pkg::PHASE_W-1:PH_FRAC]);
        fr   = longint'(osc_phase[PH_FRAC-1:0]);
        t0   = longint'(cos_rom[idx]);
        t1   = longint'(cos_rom[idx + 1]);
        smp  = t0 + rnd_shr(fr * (t1 - t0), PH_FRAC);
        // phase increment truncated toward zero, wraps mod 2^32
        prod = freq * longint'(scale_reg);
        if (prod >= 0) begin
            step = prod >>> fmop_pkg::INC_FRAC;
        end else begin
            step = -((-prod) >>> fmop_pkg::INC_FRAC);
        end
        osc_phase = osc_phase + step[fmop_pkg::PHASE_W-1:0];
        fb_freq   = clamp24(rnd_shr(smp * freq, SMP_FRAC));
        res.modv  = clamp24(rnd_shr(longint'(fb_freq) * longint'(amp_reg),
                                    fmop_pkg::AMP_FRAC));
        res.audio = clamp24(rnd_shr(longint'(amp_reg) * smp, fmop_pkg::AMP_FRAC));
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    // single process owns the predictor: register writes, accepted items, accepted results
    always @(posedge aclk) begin
        op_sample_t pred;
        op_sample_t got;
        op_sample_t want;
        if (!aresetn) begin
            reset_operator();
        end else begin
            if (cfg_wr_en) begin
                // bits above each register width are dropped
                case (cfg_addr)
                    fmop_pkg::REG_AMPLITUDE:
                        amp_reg   = cfg_wr_data[fmop_pkg::AMP_W-1:0];
                    fmop_pkg::REG_BASE_FREQ:
                        base_reg  = cfg_wr_data[fmop_pkg::FIELD_W-1:0];
                    fmop_pkg::REG_FB_GAIN:
                        gain_reg  = cfg_wr_data[fmop_pkg::GAIN_W-1:0];
                    fmop_pkg::REG_PHASE_SCALE:
                        scale_reg = cfg_wr_data[fmop_pkg::SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_operator(s_tdata[fmop_pkg::FIELD_W-1:0], pred);
                if (row_known) begin
                    pred.audio = row_audio;
                    pred.modv  = row_mod;
                end
                operator_outputs.push_back(pred);
            end
            if (m_tvalid && m_tready) begin
                got.audio = m_tdata[fmop_pkg::FIELD_W-1:0];
                got.modv  = m_tdata[2*fmop_pkg::FIELD_W-1:fmop_pkg::FIELD_W];
                if (operator_outputs.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: audio %h mod %h",
                                              got.audio, got.modv));
                end else begin
                    want = operator_outputs.pop_front();
                    if (got.audio !== want.audio) begin
                        report_mismatch($sformatf("audio_out %h, predicted %h",
                                                  got.audio, want.audio));
                    end
                    if (got.modv !== want.modv) begin
                        report_mismatch($sformatf("mod_out %h, predicted %h",
                                                  got.modv, want.modv));
                    end
                end
            end
        end
    end

    // watchdog: cycles in which no item, result or register write moves
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    // result side back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // register write while the block is idle; cfg_wr_en is dropped again before the task returns
    task automatic program_reg(input logic [fmop_pkg::CFG_ADDR_W-1:0] idx,
                               input logic [fmop_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // offer one item after a random gap; returns on the falling edge after acceptance
    // with tvalid still high, so back to back items need no lowering in between
    task automatic send_mod(input logic [fmop_pkg::FIELD_W-1:0] v, input logic known,
                            input logic [fmop_pkg::FIELD_W-1:0] ka,
                            input logic [fmop_pkg::FIELD_W-1:0] km);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 24'($urandom);
            @(negedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= v;
        row_known <= known;
        row_audio <= ka;
        row_mod   <= km;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // stop offering and wait until every owed result is out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (operator_outputs.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        logic [fmop_pkg::FIELD_W-1:0] v;
        logic [31:0]                  junk;
        logic [fmop_pkg::AMP_W-1:0]   amp;
        logic [fmop_pkg::FIELD_W-1:0] base;
        logic [fmop_pkg::GAIN_W-1:0]  gain;
        logic [fmop_pkg::SCALE_W-1:0] scale;
        bit                           musical;
        int                           seg;
        int                           n;

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table, no idling
        for (n = 0; n < N_DIRECTED; n++) begin
            if (directed_rows[n].wr) begin
                settle();
                program_reg(directed_rows[n].reg_idx, directed_rows[n].reg_val);
            end
            send_mod(directed_rows[n].mod_in, directed_rows[n].known,
                     directed_rows[n].aud_k, directed_rows[n].mod_k);
        end

        // random segments: new settings each time, cycling through the idling phases
        for (seg = 0; seg < NUM_SEGMENTS; seg++) begin
            settle();
            case (seg % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // musical settings keep the feedback loop in a sane range, the rest go anywhere
            musical = 1'($urandom_range(1));
            case ($urandom_range(5))
                0: amp = 16'h7FFF;
                1: amp = 16'h8000;
                2: amp = 16'h0000;
                default: amp = musical ? 16'($urandom_range(1024)) : 16'($urandom);
            endcase
            case ($urandom_range(5))
                0: base = 24'h7FFFFF;
                1: base = 24'h800000;
                default: base = musical ? 24'($urandom_range(1280000)) : 24'($urandom);
            endcase
            case ($urandom_range(5))
                0: gain = 16'h7FFF;
                1: gain = 16'h8000;
                default: gain = musical ? 16'($urandom_range(8191)) - 16'd4096 : 16'($urandom);
            endcase
            case ($urandom_range(7))
                0: scale = 20'd0;
                1: scale = 20'd1;
                2: scale = 20'hFFFFF;
                3: scale = 20'd536870;
                default: scale = musical ? 20'($urandom_range(30000, 5000)) : 20'($urandom);
            endcase
            // upper write data bits are junk that the block must drop
            junk = $urandom;
            if ($urandom_range(4) != 0) program_reg(fmop_pkg::REG_AMPLITUDE, {junk[7:0], amp});
            if ($urandom_range(4) != 0) program_reg(fmop_pkg::REG_BASE_FREQ, base);
            if ($urandom_range(4) != 0) program_reg(fmop_pkg::REG_FB_GAIN, {junk[15:8], gain});
            if ($urandom_range(4) != 0) begin
                program_reg(fmop_pkg::REG_PHASE_SCALE, {junk[19:16], scale});
            end

            for (n = 0; n < SEG_ITEMS; n++) begin
                case ($urandom_range(15))
                    0: v = 24'h7FFFFF;
                    1: v = 24'h800000;
                    2: v = 24'($urandom);
                    default: begin
                        if (musical) begin
                            v = 24'($urandom_range(32767)) - 24'd16384;
                        end else begin
                            v = 24'($urandom);
                        end
                    end
                endcase
                send_mod(v, 1'b0, '0, '0);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (err_count == 0 && operator_outputs.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- fm_operator_with_feedback.f -----
rtl/core/fmop_pkg.sv
rtl/core/fmop_cos_rom.sv
rtl/core/fm_operator_with_feedback.sv
rtl/core/fmop_checker.sv
verif/fm_operator_with_feedback_tb.sv
